>>> src/wbs_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
// used by every file of the block; depends on nothing
package wbs_pkg;

  localparam int MAX_PATTERN  = 16;
  localparam int OFFSET_WIDTH = 32;
  localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
  localparam int WIN_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_DATA_W   = 64;
  localparam int REG_INDEX_W  = 3;
  localparam int OUT_OFFSET_W = 32;
  localparam int REG_PATTERN_W = 64;
  localparam int REG_CARE_W   = 16;
  localparam int REG_LEN_W    = 5;
  localparam int REG_MODE_W   = 2;

  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_MATCH_MODE   = 3'd4
  } reg_index_t;

  typedef enum logic [REG_MODE_W-1:0] {
    MODE_EXACT    = 2'd0,
    MODE_WILDCARD = 2'd1,
    MODE_MASK     = 2'd2
  } match_mode_t;

  // expanded configuration as the compare logic sees it
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pattern;
    logic [MAX_PATTERN-1:0]      care;
    logic [LEN_W-1:0]            len;
    logic [REG_MODE_W-1:0]       mode;
  } cfg_t;

  // one queued item: window after the shift, count after the increment
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] window;
    logic [OFFSET_WIDTH-1:0]     count;
    logic                        last;
  } entry_t;

endpackage

>>> src/wbs_if.sv
// stream interfaces for the scanner: byte input and result output
// depends on wbs_pkg
interface wbs_in_if;
  import wbs_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbs_out_if;
  import wbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [OUT_OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink (input valid, input found, input match_offset, output ready);
endinterface

>>> src/wildcard_byte_pattern_scan_core.sv
// top level of the wildcard byte pattern scanner
// depends on wbs_pkg, wbs_if, wbs_cfg, wbs_front, wbs_queue, wbs_back
//
// Scans a byte stream, one byte per word on the data channel, for the first
// occurrence of a 1 to 16 byte pattern in each region (last_byte closes a
// region). Modes: exact, 0x3F pattern bytes as wildcards, or care mask. One
// result word per region: found with the start offset at the first match, or
// not found at the region's last byte. A byte is taken every clock cycle while
// the queue is not full. The front end shifts the window and counts, a
// two-entry queue carries each window to the back end, whose 16-byte parallel
// compare and output register finish one word per cycle while the output is
// taken. The queue and output register absorb stalls on either side until the
// queue fills. Write configuration only while the block is idle.
module wildcard_byte_pattern_scan_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [wbs_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [wbs_pkg::CFG_DATA_W-1:0]  wr_data,
  wbs_in_if.sink                          data,
  wbs_out_if.source                       result
);
  import wbs_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;

  wbs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  wbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data       (data),
    .q_full     (full),
    .push       (push),
    .push_entry (push_entry)
  );

  wbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  wbs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

>>> src/wbs_cfg.sv
// configuration registers and their expansion into per-byte pattern and care
// depends on wbs_pkg
module wbs_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [wbs_pkg::REG_INDEX_W-1:0]    wr_index,
  input  logic [wbs_pkg::CFG_DATA_W-1:0]     wr_data,
  output wbs_pkg::cfg_t                      cfg
);
  import wbs_pkg::*;

  logic [REG_PATTERN_W-1:0] pattern_low;
  logic [REG_PATTERN_W-1:0] pattern_high;
  logic [REG_CARE_W-1:0]    care_mask;
  logic [REG_LEN_W-1:0]     pattern_length;
  logic [REG_MODE_W-1:0]    match_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '1;
      pattern_length <= REG_LEN_W'(1);
      match_mode     <= MODE_EXACT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PATTERN_LOW:  pattern_low    <= wr_data[REG_PATTERN_W-1:0];
        REG_PATTERN_HIGH: pattern_high   <= wr_data[REG_PATTERN_W-1:0];
        REG_CARE_MASK:    care_mask      <= wr_data[REG_CARE_W-1:0];
        REG_PATTERN_LEN:  pattern_length <= wr_data[REG_LEN_W-1:0];
        REG_MATCH_MODE:   match_mode     <= wr_data[REG_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2*REG_PATTERN_W-1:0] pat_all;
    pat_all = {pattern_high, pattern_low};
    for (int k = 0; k < MAX_PATTERN; k++) begin
      // bytes past the two registers are zero and always cared about
      if (k < 16) begin
        cfg.pattern[k] = pat_all[8*(k%16) +: 8];
        cfg.care[k]    = care_mask[k%16];
      end else begin
        cfg.pattern[k] = 8'h00;
        cfg.care[k]    = 1'b1;
      end
    end
    // zero acts as one, oversize clamps to the window depth
    if (pattern_length == '0)
      cfg.len = LEN_W'(1);
    else if (int'(pattern_length) > MAX_PATTERN)
      cfg.len = LEN_W'(MAX_PATTERN);
    else
      cfg.len = LEN_W'(pattern_length);
    cfg.mode = match_mode;
  end

endmodule

>>> src/wbs_front.sv
// front end: accepts bytes, keeps the sliding window and the region count
// depends on wbs_pkg and wbs_if
module wbs_front (
  input  logic            clk,
  input  logic            rst,
  wbs_in_if.sink          data,
  input  logic            q_full,
  output logic            push,
  output wbs_pkg::entry_t push_entry
);
  import wbs_pkg::*;

  logic [MAX_PATTERN-1:0][7:0] window;
  logic [OFFSET_WIDTH-1:0]     count;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [OFFSET_WIDTH-1:0]     count_next;

  assign data.ready = !q_full;
  assign push       = data.valid && !q_full;

  always_comb begin
    window_next[0] = data.data_byte;
    for (int i = 1; i < MAX_PATTERN; i++)
      window_next[i] = window[i-1];
    // saturating count
    count_next = (count == '1) ? count : count + OFFSET_WIDTH'(1);
  end

  assign push_entry.window = window_next;
  assign push_entry.count  = count_next;
  assign push_entry.last   = data.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      count  <= '0;
    end else if (push) begin
      if (data.last_byte) begin
        window <= '0;
        count  <= '0;
      end else begin
        window <= window_next;
        count  <= count_next;
      end
    end
  end

endmodule

>>> src/wbs_queue.sv
// short queue between the front and back ends
// depends on wbs_pkg
module wbs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wbs_pkg::entry_t push_entry,
  input  logic            pop,
  output wbs_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import wbs_pkg::*;

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop)
        fill <= fill + QCNT_W'(1);
      else if (pop && !push)
        fill <= fill - QCNT_W'(1);
    end
  end

endmodule

>>> src/wbs_back.sv
// back end: compares each queued window against the pattern, tracks the
// first match of a region and holds the result word; depends on wbs_pkg, wbs_if
module wbs_back (
  input  logic            clk,
  input  logic            rst,
  input  wbs_pkg::cfg_t   cfg,
  input  wbs_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  wbs_out_if.source       result
);
  import wbs_pkg::*;

  logic                    already_matched;
  logic                    out_valid;
  logic                    out_found;
  logic [OUT_OFFSET_W-1:0] out_offset;

  logic                    window_hit;
  logic                    long_enough;
  logic                    hit;
  logic                    emit;
  logic [OFFSET_WIDTH-1:0] start;

  assign pop = !empty && (!out_valid || result.ready);

  always_comb begin
    logic [7:0]          p;
    logic [7:0]          d;
    logic                ok;
    logic [LEN_W:0]      j;
    window_hit = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      p = cfg.pattern[k];
      // pattern byte k lines up with the byte len-1-k positions back
      j = {1'b0, cfg.len} - (LEN_W+1)'(1) - (LEN_W+1)'(k);
      d = head.window[j[WIN_IDX_W-1:0]];
      case (cfg.mode)
        MODE_WILDCARD: ok = (p == WILDCARD_BYTE) || (d == p);
        MODE_MASK:     ok = !cfg.care[k] || (d == p);
        default:       ok = (d == p);
      endcase
      if (k < int'(cfg.len) && !ok)
        window_hit = 1'b0;
    end
  end

  assign long_enough = head.count >= OFFSET_WIDTH'(cfg.len);
  assign hit         = !already_matched && long_enough && window_hit;
  assign emit        = hit || (head.last && !already_matched);
  assign start       = head.count - OFFSET_WIDTH'(cfg.len);

  always_ff @(posedge clk) begin
    logic [OFFSET_WIDTH+OUT_OFFSET_W-1:0] start_ext;
    start_ext = {{OUT_OFFSET_W{1'b0}}, start};
    if (rst) begin
      already_matched <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // a pop only happens when the held word is gone or leaves at this edge
      if (pop)
        out_valid <= emit;
      else if (result.ready)
        out_valid <= 1'b0;
      if (pop) begin
        if (head.last)
          already_matched <= 1'b0;
        else if (hit)
          already_matched <= 1'b1;
      end
    end
    if (pop && emit) begin
      out_found  <= hit;
      out_offset <= hit ? start_ext[OUT_OFFSET_W-1:0] : '0;
    end
  end

  assign result.valid        = out_valid;
  assign result.found        = out_found;
  assign result.match_offset = out_offset;

endmodule

>>> tb/tb_wildcard_byte_pattern_scan_core.sv
// self-checking bench for the wildcard byte pattern scanner: random regions with planted
// pattern copies, predicted in-line and checked word by word on the result channel
// depends on wbs_pkg, wbs_in_if, wbs_out_if and wildcard_byte_pattern_scan_core
module tb_wildcard_byte_pattern_scan_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wbs_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } region_byte_t;

  typedef struct {
    logic                    found;
    logic [OUT_OFFSET_W-1:0] offset;
  } scan_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  wbs_in_if  byte_ch ();
  wbs_out_if report_ch ();

  wildcard_byte_pattern_scan_core dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .data     (byte_ch),
    .result   (report_ch)
  );

  region_byte_t bytes_to_send [$];
  scan_report_t reports_due [$];
  logic in_taken = 1'b0;
  logic no_gaps = 1'b0;
  int errors = 0;

  // shadow of the scanner: registers, window (index 0 newest), count, match flag
  logic [REG_PATTERN_W-1:0] pat_lo_q = '0;
  logic [REG_PATTERN_W-1:0] pat_hi_q = '0;
  logic [REG_CARE_W-1:0] care_q = '1;
  logic [REG_LEN_W-1:0] len_q = 5'd1;
  logic [REG_MODE_W-1:0] mode_q = MODE_EXACT;
  logic [7:0] win_q [MAX_PATTERN] = '{default: 8'h00};
  logic [OFFSET_WIDTH-1:0] seen_q = '0;
  logic hit_done_q = 1'b0;

  always #5 clk = ~clk;

  function automatic int unsigned active_len();
    if (len_q == 0) return 1;
    if (len_q > MAX_PATTERN) return MAX_PATTERN;
    return len_q;
  endfunction

  function automatic logic [7:0] pattern_at(int k);
    logic [2*REG_PATTERN_W-1:0] both;
    both = {pat_hi_q, pat_lo_q};
    return both[8*k +: 8];
  endfunction

  function automatic logic window_hit(int unsigned len);
    logic [7:0] p;
    logic [7:0] d;
    logic ok;
    for (int k = 0; k < len; k++) begin
      p = pattern_at(k);
      d = win_q[len-1-k];
      case (mode_q)
        MODE_WILDCARD: ok = (p == WILDCARD_BYTE) || (d == p);
        MODE_MASK:     ok = !care_q[k] || (d == p);
        default:       ok = (d == p);
      endcase
      if (!ok) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the shadow by one accepted byte, queue the report it causes
  function automatic void scan_byte(logic [7:0] d, logic last);
    int unsigned len;
    len = active_len();
    for (int i = MAX_PATTERN - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = d;
    if (seen_q != '1) seen_q = seen_q + 1'b1;
    if (!hit_done_q && seen_q >= len && window_hit(len)) begin
      hit_done_q = 1'b1;
      reports_due.push_back('{found: 1'b1, offset: OUT_OFFSET_W'(seen_q - len)});
    end else if (last && !hit_done_q) begin
      reports_due.push_back('{found: 1'b0, offset: '0});
    end
    if (last) begin
      win_q = '{default: 8'h00};
      seen_q = '0;
      hit_done_q = 1'b0;
    end
  endfunction

  // byte that satisfies pattern position k; free positions get random content
  function automatic logic [7:0] pattern_copy_byte(int k);
    logic [7:0] p;
    p = pattern_at(k);
    if ((mode_q == MODE_WILDCARD && p == WILDCARD_BYTE) || (mode_q == MODE_MASK && !care_q[k]))
      return 8'($urandom_range(255));
    return p;
  endfunction

  function automatic logic [REG_PATTERN_W-1:0] rand_pattern();
    logic [REG_PATTERN_W-1:0] v;
    v = {$urandom, $urandom};
    for (int k = 0; k < 8; k++)
      if ($urandom_range(9) < 3) v[8*k +: 8] = WILDCARD_BYTE;
    return v;
  endfunction

  task automatic set_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    case (idx)
      REG_PATTERN_LOW:  pat_lo_q = v;
      REG_PATTERN_HIGH: pat_hi_q = v;
      REG_CARE_MASK:    care_q = v[REG_CARE_W-1:0];
      REG_PATTERN_LEN:  len_q = v[REG_LEN_W-1:0];
      REG_MATCH_MODE:   mode_q = v[REG_MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_scan(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] care, input logic [4:0] len,
                              input logic [1:0] mode);
    set_reg(REG_PATTERN_LOW, lo);
    set_reg(REG_PATTERN_HIGH, hi);
    set_reg(REG_CARE_MASK, CFG_DATA_W'(care));
    set_reg(REG_PATTERN_LEN, CFG_DATA_W'(len));
    set_reg(REG_MATCH_MODE, CFG_DATA_W'(mode));
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic send(input logic [7:0] b, input logic last);
    bytes_to_send.push_back('{value: b, last: last});
  endtask

  // wait for the block to drain, then give in-flight no-report bytes time to retire
  task automatic settle();
    while (bytes_to_send.size() != 0 || byte_ch.valid || reports_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_region(output int unsigned n);
    logic [7:0] body [$];
    int unsigned plen;
    int unsigned kind;
    int unsigned reps;
    int unsigned wrong;
    int unsigned cnt;
    plen = active_len();
    kind = $urandom_range(99);
    if (kind < 55) begin
      repeat ($urandom_range(12)) body.push_back(8'($urandom_range(255)));
      reps = (kind < 10) ? 2 : 1;
      repeat (reps) begin
        // one copy in four is a near miss
        wrong = ($urandom_range(3) == 0) ? $urandom_range(plen - 1) : plen;
        for (int k = 0; k < plen; k++)
          body.push_back((k == wrong) ? pattern_copy_byte(k) ^ (8'h01 << $urandom_range(7))
                                      : pattern_copy_byte(k));
      end
      repeat ($urandom_range(6)) body.push_back(8'($urandom_range(255)));
    end else if (kind < 75) begin
      repeat ($urandom_range(24, 1)) body.push_back(8'($urandom_range(255)));
    end else if (kind < 90) begin
      // region shorter than the pattern (one byte for a one-byte pattern), built from its leading bytes
      cnt = (plen > 1) ? $urandom_range(plen - 1, 1) : 1;
      for (int k = 0; k < cnt; k++) body.push_back(pattern_copy_byte(k));
    end else begin
      repeat ($urandom_range(40, 4)) body.push_back(pattern_copy_byte($urandom_range(plen - 1)));
    end
    foreach (body[i]) send(body[i], i == body.size() - 1);
    n = body.size();
  endtask

  // drive the byte channel and the result ready
  always @(negedge clk) begin : drive_ports
    region_byte_t w;
    logic nv;
    logic [7:0] nb;
    logic nl;
    nv = byte_ch.valid;
    nb = byte_ch.data_byte;
    nl = byte_ch.last_byte;
    if (rst) begin
      nv = 1'b0;
    end else if (!byte_ch.valid || in_taken) begin
      if (bytes_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 23)) begin
        w = bytes_to_send.pop_front();
        nv = 1'b1;
        nb = w.value;
        nl = w.last;
      end else begin
        nv = 1'b0;
      end
    end
    byte_ch.valid <= nv;
    byte_ch.data_byte <= nb;
    byte_ch.last_byte <= nl;
    report_ch.ready <= !rst && (no_gaps || $urandom_range(99) >= 23);
  end

  // check result words, then predict from the byte taken at this edge
  always @(posedge clk) begin : watch_ports
    scan_report_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= byte_ch.valid && byte_ch.ready;
      if (report_ch.valid && report_ch.ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word found=%0b offset=%0d", $time,
                   report_ch.found, report_ch.match_offset);
        end else begin
          want = reports_due.pop_front();
          if (report_ch.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0b actual %0b", $time, want.found,
                     report_ch.found);
          end
          if (report_ch.match_offset !== want.offset) begin
            errors++;
            $display("%0t: match_offset expected %0d actual %0d", $time, want.offset,
                     report_ch.match_offset);
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) scan_byte(byte_ch.data_byte, byte_ch.last_byte);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] care;
    logic [4:0] len;
    logic [1:0] mode;
    wr_en = 1'b0;
    wr_index = REG_PATTERN_LOW;
    wr_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    report_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one zero byte, match on the last byte, then a miss
    send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    send(8'hFF, 1'b1);
    settle();

    // wildcard in the second position; a region too short for the pattern
    program_scan(64'h0000_0000_5634_3F12, 64'h0, 16'hFFFF, 5'd4, MODE_WILDCARD);
    send(8'h12, 1'b0);
    send(8'h99, 1'b0);
    send(8'h34, 1'b0);
    send(8'h56, 1'b1);
    send(8'h34, 1'b0);
    send(8'h56, 1'b1);
    settle();

    // unused mode acts as exact: 0x3f only matches itself
    program_scan(64'h0000_0000_5634_3F12, 64'h0, 16'hFFFF, 5'd4, MODE_SPARE);
    send(8'h12, 1'b0);
    send(8'h3F, 1'b0);
    send(8'h34, 1'b0);
    send(8'h56, 1'b1);
    send(8'h12, 1'b0);
    send(8'h77, 1'b0);
    send(8'h34, 1'b0);
    send(8'h56, 1'b1);
    settle();

    // length zero counts as one, empty care mask matches anything
    program_scan(64'h0, 64'h0, 16'h0000, 5'd0, MODE_MASK);
    send(8'hAB, 1'b1);
    send(8'h00, 1'b0);
    send(8'h01, 1'b1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      lo = rand_pattern();
      hi = rand_pattern();
      care = 16'($urandom);
      len = 5'($urandom_range(16, 1));
      mode = 2'($urandom_range(3));
      case (ph)
        0: begin
          lo = '1;
          hi = '1;
          care = 16'hFFFF;
          len = 5'd16;
          mode = MODE_EXACT;
        end
        1: begin
          lo = '0;
          hi = '0;
          care = 16'h0000;
          len = 5'd1;
          mode = MODE_MASK;
        end
        2: begin
          len = 5'd31;
          mode = MODE_WILDCARD;
        end
        3: begin
          len = 5'd17;
          mode = MODE_MASK;
        end
        default: ;
      endcase
      program_scan(lo, hi, care, len, mode);
      no_gaps = (ph == 4);
      sent = 0;
      while (sent < 90) begin
        add_region(n);
        sent += n;
      end
      settle();
      no_gaps = 1'b0;
    end

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
